FILE: design/assert_macros.svh
// Assertion macros shared by the modular arithmetic unit.
// Each use names the clock aclk and the active-low reset aresetn of the module it sits in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every edge outside reset.
`define MAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/mau_pkg.sv
// Types, constants and helpers of the modular arithmetic unit.
// Used by mau_datapath, mau_ctrl, modular_arithmetic_unit and the testbench; depends on nothing.
package mau_pkg;

    localparam int MOD_W     = 31;
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd998244353;
    localparam logic [CNT_W-1:0] RED_STEPS     = 7'd64;
    localparam logic [CNT_W-1:0] MUL_STEPS     = 7'd31;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_POW = 3'd4,
        ACT_INV = 3'd5,
        ACT_NEG = 3'd6,
        ACT_RED = 3'd7
    } action_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RED_A,
        CMD_FIX_A,
        CMD_RED_B,
        CMD_FIX_B,
        CMD_ARITH,
        CMD_MUL_AB,
        CMD_MUL_AU,
        CMD_RES_P,
        CMD_INV_INIT,
        CMD_DIV,
        CMD_EUC_UPD,
        CMD_POW_INIT,
        CMD_BASE_INV,
        CMD_MUL_ACC,
        CMD_MUL_SQ,
        CMD_TAKE_ACC,
        CMD_TAKE_SQ,
        CMD_RES_ACC,
        CMD_RES_INV,
        CMD_FAIL,
        CMD_SEND
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_A,
        ST_WAIT_A,
        ST_RED_B,
        ST_WAIT_B,
        ST_DISPATCH,
        ST_MUL_WAIT,
        ST_INV_INIT,
        ST_INV_TEST,
        ST_DIV_WAIT,
        ST_POW_INIT,
        ST_POW_TEST,
        ST_ACC_WAIT,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    ser_busy;
        logic    e_zero;
        logic    e_lsb;
        logic    right_neg;
        logic    y_zero;
        logic    x_one;
        logic    out_free;
        action_t action;
    } status_t;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 64'd1) : v;
    endfunction

    // Lift the remainder of a negative operand to its non-negative residue.
    function automatic logic [MOD_W-1:0] sign_fix(input logic neg,
                                                  input logic [MOD_W-1:0] r,
                                                  input logic [MOD_W-1:0] m);
        return (neg && (r != '0)) ? (m - r) : r;
    endfunction

endpackage

FILE: design/mau_datapath.sv
// Datapath of the modular arithmetic unit: operand, Euclid and power registers,
// the bit-serial modular multiply / divide engine and the result register. Uses mau_pkg.
`include "assert_macros.svh"

module mau_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mau_pkg::cmd_t                     cmd,
    input  logic [mau_pkg::MOD_W-1:0]         modulus,
    input  logic [2:0]                        s_action,
    input  logic signed [mau_pkg::DATA_W-1:0] s_left_value,
    input  logic signed [mau_pkg::DATA_W-1:0] s_right_value,
    input  logic                              m_ready,
    output mau_pkg::status_t                  status,
    output logic                              m_valid,
    output logic [mau_pkg::MOD_W-1:0]         m_result_value,
    output logic                              m_failed
);

    localparam int MW = mau_pkg::MOD_W;
    localparam int DW = mau_pkg::DATA_W;
    localparam int PAD = DW - MW;

    logic [MW-1:0]    m_eff;
    logic [MW-1:0]    one_mod;

    mau_pkg::action_t act_reg, act_next;
    logic [DW-1:0]    left_reg, left_next, right_reg, right_next, e_reg, e_next;
    logic [MW-1:0]    a_reg, a_next, b_reg, b_next, acc_reg, acc_next, base_reg, base_next;
    logic [MW-1:0]    x_reg, x_next, y_reg, y_next, cu_reg, cu_next, cv_reg, cv_next;
    logic [MW-1:0]    rem_reg, rem_next, p_reg, p_next, addend_reg, addend_next;
    logic [DW-1:0]    sh_reg, sh_next;
    logic [mau_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic [MW-1:0]    res_reg, res_next;
    logic             fail_reg, fail_next;
    logic             m_valid_reg, m_valid_next;
    logic [MW-1:0]    m_result_reg, m_result_next;
    logic             m_failed_reg, m_failed_next;

    // Serial engine step signals
    logic [MW:0]      rem_sh, rem_sub, dbl, dbl_r, sum, sum_r, arith_sum, arith_r, cv_diff;
    logic             div_ge, mbit;

    assign m_eff   = (modulus == '0) ? {{(MW-1){1'b0}}, 1'b1} : modulus;
    assign one_mod = {{(MW-1){1'b0}}, (m_eff != {{(MW-1){1'b0}}, 1'b1})};

    always_comb begin
        rem_sh  = {rem_reg, sh_reg[DW-1]};
        div_ge  = rem_sh >= {1'b0, y_reg};
        rem_sub = div_ge ? (rem_sh - {1'b0, y_reg}) : rem_sh;
        mbit    = div_reg ? div_ge : sh_reg[DW-1];
        dbl     = {p_reg, 1'b0};
        dbl_r   = (dbl >= {1'b0, m_eff}) ? (dbl - {1'b0, m_eff}) : dbl;
        sum     = dbl_r + (mbit ? {1'b0, addend_reg} : '0);
        sum_r   = (sum >= {1'b0, m_eff}) ? (sum - {1'b0, m_eff}) : sum;
    end

    always_comb begin
        unique case (act_reg)
            mau_pkg::ACT_ADD: arith_sum = {1'b0, a_reg} + {1'b0, b_reg};
            mau_pkg::ACT_SUB: arith_sum = {1'b0, a_reg} + {1'b0, m_eff} - {1'b0, b_reg};
            mau_pkg::ACT_NEG: arith_sum = {1'b0, m_eff} - {1'b0, a_reg};
            default:          arith_sum = {1'b0, a_reg};
        endcase
        arith_r = (arith_sum >= {1'b0, m_eff}) ? (arith_sum - {1'b0, m_eff}) : arith_sum;
        cv_diff = (cu_reg >= p_reg) ? ({1'b0, cu_reg} - {1'b0, p_reg})
                                    : ({1'b0, cu_reg} + {1'b0, m_eff} - {1'b0, p_reg});
    end

    always_comb begin
        act_next      = act_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        e_next        = e_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        cu_next       = cu_reg;
        cv_next       = cv_reg;
        rem_next      = rem_reg;
        p_next        = p_reg;
        addend_next   = addend_reg;
        sh_next       = sh_reg;
        cnt_next      = cnt_reg;
        div_next      = div_reg;
        res_next      = res_reg;
        fail_next     = fail_reg;
        m_result_next = m_result_reg;
        m_failed_next = m_failed_reg;
        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;

        // advance the serial engine one bit
        if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            sh_next  = {sh_reg[DW-2:0], 1'b0};
            rem_next = rem_sub[MW-1:0];
            p_next   = sum_r[MW-1:0];
        end

        unique case (cmd)
            mau_pkg::CMD_LOAD: begin
                act_next   = mau_pkg::action_t'(s_action);
                left_next  = $unsigned(s_left_value);
                right_next = $unsigned(s_right_value);
            end
            mau_pkg::CMD_RED_A, mau_pkg::CMD_RED_B: begin
                sh_next     = mau_pkg::magnitude((cmd == mau_pkg::CMD_RED_A) ? left_reg
                                                                             : right_reg);
                addend_next = one_mod;
                cnt_next    = mau_pkg::RED_STEPS;
                div_next    = 1'b0;
                p_next      = '0;
                rem_next    = '0;
            end
            mau_pkg::CMD_FIX_A: a_next = mau_pkg::sign_fix(left_reg[DW-1], p_reg, m_eff);
            mau_pkg::CMD_FIX_B: b_next = mau_pkg::sign_fix(right_reg[DW-1], p_reg, m_eff);
            mau_pkg::CMD_ARITH: begin
                res_next  = arith_r[MW-1:0];
                fail_next = 1'b0;
            end
            mau_pkg::CMD_MUL_AB, mau_pkg::CMD_MUL_AU, mau_pkg::CMD_MUL_ACC,
            mau_pkg::CMD_MUL_SQ, mau_pkg::CMD_DIV: begin
                unique case (cmd)
                    mau_pkg::CMD_MUL_AB:  sh_next = {b_reg, {PAD{1'b0}}};
                    mau_pkg::CMD_MUL_AU:  sh_next = {cu_reg, {PAD{1'b0}}};
                    mau_pkg::CMD_MUL_ACC: sh_next = {acc_reg, {PAD{1'b0}}};
                    mau_pkg::CMD_MUL_SQ:  sh_next = {base_reg, {PAD{1'b0}}};
                    default:              sh_next = {x_reg, {PAD{1'b0}}};
                endcase
                unique case (cmd)
                    mau_pkg::CMD_MUL_ACC, mau_pkg::CMD_MUL_SQ: addend_next = base_reg;
                    mau_pkg::CMD_DIV:                          addend_next = cv_reg;
                    default:                                   addend_next = a_reg;
                endcase
                div_next = (cmd == mau_pkg::CMD_DIV);
                cnt_next = mau_pkg::MUL_STEPS;
                p_next   = '0;
                rem_next = '0;
            end
            mau_pkg::CMD_RES_P: begin
                res_next  = p_reg;
                fail_next = 1'b0;
            end
            mau_pkg::CMD_INV_INIT: begin
                x_next  = (act_reg == mau_pkg::ACT_DIV) ? b_reg : a_reg;
                y_next  = m_eff;
                cu_next = one_mod;
                cv_next = '0;
            end
            mau_pkg::CMD_EUC_UPD: begin
                x_next  = y_reg;
                y_next  = rem_reg;
                cu_next = cv_reg;
                cv_next = cv_diff[MW-1:0];
            end
            mau_pkg::CMD_POW_INIT: begin
                acc_next  = one_mod;
                base_next = a_reg;
                e_next    = mau_pkg::magnitude(right_reg);
            end
            mau_pkg::CMD_BASE_INV: base_next = cu_reg;
            mau_pkg::CMD_TAKE_ACC: acc_next = p_reg;
            mau_pkg::CMD_TAKE_SQ: begin
                base_next = p_reg;
                e_next    = {1'b0, e_reg[DW-1:1]};
            end
            mau_pkg::CMD_RES_ACC: begin
                res_next  = acc_reg;
                fail_next = 1'b0;
            end
            mau_pkg::CMD_RES_INV: begin
                res_next  = cu_reg;
                fail_next = 1'b0;
            end
            mau_pkg::CMD_FAIL: begin
                res_next  = '0;
                fail_next = 1'b1;
            end
            mau_pkg::CMD_SEND: begin
                m_valid_next  = 1'b1;
                m_result_next = res_reg;
                m_failed_next = fail_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        e_reg        <= e_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        cu_reg       <= cu_next;
        cv_reg       <= cv_next;
        rem_reg      <= rem_next;
        p_reg        <= p_next;
        addend_reg   <= addend_next;
        sh_reg       <= sh_next;
        div_reg      <= div_next;
        res_reg      <= res_next;
        fail_reg     <= fail_next;
        m_result_reg <= m_result_next;
        m_failed_reg <= m_failed_next;
    end

    always_comb begin
        status.ser_busy  = (cnt_reg != '0);
        status.e_zero    = (e_reg == '0);
        status.e_lsb     = e_reg[0];
        status.right_neg = right_reg[DW-1];
        status.y_zero    = (y_reg == '0);
        status.x_one     = (x_reg == {{(MW-1){1'b0}}, 1'b1});
        status.out_free  = !m_valid_reg || m_ready;
        status.action    = act_reg;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_failed       = m_failed_reg;

    `MAU_ASSERT(a_fail_zero, (m_valid_reg && m_failed_reg |-> m_result_reg == '0), "failed result not zero")
    `MAU_ASSERT(a_result_range, (m_valid_reg |-> m_result_reg < m_eff), "result not below modulus")
    `MAU_ASSERT_NEXT(a_start_busy, (cmd == mau_pkg::CMD_DIV || cmd == mau_pkg::CMD_MUL_SQ), (cnt_reg != '0), "serial engine did not start")

endmodule

FILE: design/mau_ctrl.sv
// Sequencer of the modular arithmetic unit: steps reduction, Euclid and power loops.
// Drives mau_datapath by command; uses mau_pkg.
module mau_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mau_pkg::status_t status,
    output mau_pkg::cmd_t    cmd
);

    mau_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mau_pkg::ST_IDLE:   if (s_valid) state_next = mau_pkg::ST_RED_A;
            mau_pkg::ST_RED_A:  state_next = mau_pkg::ST_WAIT_A;
            mau_pkg::ST_WAIT_A: begin
                if (!status.ser_busy) begin
                    state_next = (status.action == mau_pkg::ACT_POW) ? mau_pkg::ST_POW_INIT
                                                                     : mau_pkg::ST_RED_B;
                end
            end
            mau_pkg::ST_RED_B:  state_next = mau_pkg::ST_WAIT_B;
            mau_pkg::ST_WAIT_B: if (!status.ser_busy) state_next = mau_pkg::ST_DISPATCH;
            mau_pkg::ST_DISPATCH: begin
                unique case (status.action)
                    mau_pkg::ACT_MUL:                  state_next = mau_pkg::ST_MUL_WAIT;
                    mau_pkg::ACT_DIV, mau_pkg::ACT_INV: state_next = mau_pkg::ST_INV_INIT;
                    default:                           state_next = mau_pkg::ST_DONE;
                endcase
            end
            mau_pkg::ST_MUL_WAIT: if (!status.ser_busy) state_next = mau_pkg::ST_DONE;
            mau_pkg::ST_INV_INIT: state_next = mau_pkg::ST_INV_TEST;
            mau_pkg::ST_INV_TEST: begin
                priority if (!status.y_zero) begin
                    state_next = mau_pkg::ST_DIV_WAIT;
                end else if (!status.x_one) begin
                    state_next = mau_pkg::ST_DONE;
                end else if (status.action == mau_pkg::ACT_DIV) begin
                    state_next = mau_pkg::ST_MUL_WAIT;
                end else if (status.action == mau_pkg::ACT_POW) begin
                    state_next = mau_pkg::ST_POW_TEST;
                end else begin
                    state_next = mau_pkg::ST_DONE;
                end
            end
            mau_pkg::ST_DIV_WAIT: if (!status.ser_busy) state_next = mau_pkg::ST_INV_TEST;
            mau_pkg::ST_POW_INIT: begin
                state_next = status.right_neg ? mau_pkg::ST_INV_INIT : mau_pkg::ST_POW_TEST;
            end
            mau_pkg::ST_POW_TEST: begin
                priority if (status.e_zero) state_next = mau_pkg::ST_DONE;
                else if (status.e_lsb)      state_next = mau_pkg::ST_ACC_WAIT;
                else                        state_next = mau_pkg::ST_SQ_WAIT;
            end
            mau_pkg::ST_ACC_WAIT: if (!status.ser_busy) state_next = mau_pkg::ST_SQ_START;
            mau_pkg::ST_SQ_START: state_next = mau_pkg::ST_SQ_WAIT;
            mau_pkg::ST_SQ_WAIT:  if (!status.ser_busy) state_next = mau_pkg::ST_POW_TEST;
            mau_pkg::ST_DONE:     if (status.out_free) state_next = mau_pkg::ST_IDLE;
            default:              state_next = mau_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = mau_pkg::CMD_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            mau_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = mau_pkg::CMD_LOAD;
            end
            mau_pkg::ST_RED_A:  cmd = mau_pkg::CMD_RED_A;
            mau_pkg::ST_WAIT_A: if (!status.ser_busy) cmd = mau_pkg::CMD_FIX_A;
            mau_pkg::ST_RED_B:  cmd = mau_pkg::CMD_RED_B;
            mau_pkg::ST_WAIT_B: if (!status.ser_busy) cmd = mau_pkg::CMD_FIX_B;
            mau_pkg::ST_DISPATCH: begin
                unique case (status.action)
                    mau_pkg::ACT_MUL:                  cmd = mau_pkg::CMD_MUL_AB;
                    mau_pkg::ACT_DIV, mau_pkg::ACT_INV: cmd = mau_pkg::CMD_NONE;
                    default:                           cmd = mau_pkg::CMD_ARITH;
                endcase
            end
            mau_pkg::ST_MUL_WAIT: if (!status.ser_busy) cmd = mau_pkg::CMD_RES_P;
            mau_pkg::ST_INV_INIT: cmd = mau_pkg::CMD_INV_INIT;
            mau_pkg::ST_INV_TEST: begin
                priority if (!status.y_zero)              cmd = mau_pkg::CMD_DIV;
                else if (!status.x_one)                   cmd = mau_pkg::CMD_FAIL;
                else if (status.action == mau_pkg::ACT_DIV) cmd = mau_pkg::CMD_MUL_AU;
                else if (status.action == mau_pkg::ACT_POW) cmd = mau_pkg::CMD_BASE_INV;
                else                                      cmd = mau_pkg::CMD_RES_INV;
            end
            mau_pkg::ST_DIV_WAIT: if (!status.ser_busy) cmd = mau_pkg::CMD_EUC_UPD;
            mau_pkg::ST_POW_INIT: cmd = mau_pkg::CMD_POW_INIT;
            mau_pkg::ST_POW_TEST: begin
                priority if (status.e_zero) cmd = mau_pkg::CMD_RES_ACC;
                else if (status.e_lsb)      cmd = mau_pkg::CMD_MUL_ACC;
                else                        cmd = mau_pkg::CMD_MUL_SQ;
            end
            mau_pkg::ST_ACC_WAIT: if (!status.ser_busy) cmd = mau_pkg::CMD_TAKE_ACC;
            mau_pkg::ST_SQ_START: cmd = mau_pkg::CMD_MUL_SQ;
            mau_pkg::ST_SQ_WAIT:  if (!status.ser_busy) cmd = mau_pkg::CMD_TAKE_SQ;
            mau_pkg::ST_DONE:     if (status.out_free) cmd = mau_pkg::CMD_SEND;
            default:              cmd = mau_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mau_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, sub, mul, div, signed pow, inverse, negate and reduce of
// signed 64-bit operands modulo a 31-bit modulus (0 or 1 act as 1). One request at a time;
// every operand reduction, modular product and Euclid step runs through one bit-serial
// shift-and-add engine, and pow with a negative exponent first takes an inverse. A finished
// result waits in the output register while the next request enters. Uses mau_pkg,
// mau_ctrl and mau_datapath; modulus is written over the APB-style port.
module modular_arithmetic_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_action,
    input  logic signed [mau_pkg::DATA_W-1:0]  s_left_value,
    input  logic signed [mau_pkg::DATA_W-1:0]  s_right_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mau_pkg::MOD_W-1:0]          m_result_value,
    output logic                               m_failed,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mau_pkg::PADDR_W-1:0]        paddr,
    input  logic [mau_pkg::PDATA_W-1:0]        pwdata,
    output logic [mau_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [mau_pkg::MOD_W-1:0] modulus_reg, modulus_next;
    logic                      sel_modulus;
    mau_pkg::status_t          status;
    mau_pkg::cmd_t             cmd;

    assign pready      = 1'b1;
    assign sel_modulus = (paddr[mau_pkg::PADDR_W-1] == 1'b0);

    always_comb begin
        modulus_next = modulus_reg;
        if (psel && penable && pwrite && sel_modulus) modulus_next = pwdata[mau_pkg::MOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= mau_pkg::MODULUS_RESET;
        end else begin
            modulus_reg <= modulus_next;
        end
    end

    assign prdata = sel_modulus ? {1'b0, modulus_reg} : '0;

    mau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mau_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .modulus        (modulus_reg),
        .s_action       (s_action),
        .s_left_value   (s_left_value),
        .s_right_value  (s_right_value),
        .m_ready        (m_ready),
        .status         (status),
        .m_valid        (m_valid),
        .m_result_value (m_result_value),
        .m_failed       (m_failed)
    );

endmodule

FILE: tb/testbench.sv
// Testbench of the modular arithmetic unit: directed and random requests across several
// moduli, checked field by field against a behavioural predictor. Depends on mau_pkg and modular_arithmetic_unit.
module testbench;

    localparam logic [mau_pkg::PADDR_W-1:0] REG_MODULUS = 3'd0;
    localparam int                          STALL_LIMIT = 40000;

    typedef struct packed {
        logic [mau_pkg::MOD_W-1:0] value;
        logic                      fail;
    } outcome_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [2:0]                        s_action = '0;
    logic signed [mau_pkg::DATA_W-1:0] s_left_value = '0;
    logic signed [mau_pkg::DATA_W-1:0] s_right_value = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [mau_pkg::MOD_W-1:0]         m_result_value;
    logic                              m_failed;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [mau_pkg::PADDR_W-1:0]       paddr = '0;
    logic [mau_pkg::PDATA_W-1:0]       pwdata = '0;
    logic [mau_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;

    outcome_t    pending_results[$];
    logic [63:0] modulus_now = 64'd998244353;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;

    modular_arithmetic_unit i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] residue(input logic [63:0] raw, input logic [63:0] m);
        logic [63:0] r;
        if (raw[63]) begin
            r = (~raw + 64'd1) % m;
            return (r == 64'd0) ? 64'd0 : m - r;
        end
        return raw % m;
    endfunction

    // Extended Euclid; ok is cleared when the gcd is not one.
    function automatic logic [63:0] inverse_of(input logic [63:0] a, input logic [63:0] m,
                                                output bit ok);
        longint x, y, cu, cv, q, t;
        x = a; y = m; cu = 1; cv = 0;
        while (y != 0) begin
            q = x / y; t = x - q * y; x = y; y = t;
            t = cu - q * cv; cu = cv; cv = t;
        end
        ok = (x == 1);
        if (!ok) return 64'd0;
        return residue(cu, m);
    endfunction

    function automatic outcome_t predict_outcome(input logic [2:0] act,
                                                 input logic [63:0] lv, input logic [63:0] rv);
        logic [63:0] m, a, b, base, e, acc, t;
        bit          ok;
        outcome_t    o;
        m = (modulus_now == 64'd0) ? 64'd1 : modulus_now;
        a = residue(lv, m);
        b = residue(rv, m);
        o = '0;
        acc = 64'd0;
        case (mau_pkg::action_t'(act))
            mau_pkg::ACT_ADD: acc = (a + b) % m;
            mau_pkg::ACT_SUB: acc = (a + m - b) % m;
            mau_pkg::ACT_MUL: acc = (a * b) % m;
            mau_pkg::ACT_DIV: begin
                t = inverse_of(b, m, ok);
                if (ok) acc = (a * t) % m; else o.fail = 1'b1;
            end
            mau_pkg::ACT_POW: begin
                base = a; e = rv; acc = 64'd1 % m;
                if (e[63]) begin
                    base = inverse_of(a, m, ok);
                    if (!ok) o.fail = 1'b1;
                    e = ~e + 64'd1;
                end
                if (!o.fail) begin
                    while (e != 64'd0) begin
                        if (e[0]) acc = (acc * base) % m;
                        base = (base * base) % m;
                        e = e >> 1;
                    end
                end
            end
            mau_pkg::ACT_INV: begin
                t = inverse_of(a, m, ok);
                if (ok) acc = t; else o.fail = 1'b1;
            end
            mau_pkg::ACT_NEG: acc = (m - a) % m;
            default: acc = a;
        endcase
        o.value = o.fail ? '0 : acc[mau_pkg::MOD_W-1:0];
        return o;
    endfunction

    // Receiver: random stalls, or a long hold when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: value %0d", m_result_value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value, m_result_value);
                    error_count++;
                end
                if (m_failed !== want.fail) begin
                    $error("failed: expected %0d, got %0d", want.fail, m_failed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Hold valid after a request until the next one or an idle cycle replaces it.
    task automatic send_request(input logic [2:0] act, input logic [63:0] lv,
                                input logic [63:0] rv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_left_value <= lv;
        s_right_value <= rv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_outcome(act, lv, rv));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MODULUS; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        modulus_now = 64'(value & 32'h7FFF_FFFF);
    endtask

    function automatic logic [63:0] random_operand();
        case ($urandom_range(4))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(20));
            2: return -$signed(64'($urandom_range(20)));
            3: return modulus_now * $urandom_range(3) + $urandom_range(2) - 1;
            default: return 64'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] random_exponent();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return $signed(64'($urandom_range(40))) - 20;
            default: return 64'($urandom_range(1000));
        endcase
    endfunction

    task automatic test_directed();
        logic [63:0] lo, hi;
        lo = 64'h8000_0000_0000_0000;
        hi = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int a = 0; a < 8; a++) send_request(a[2:0], lo, hi);
        for (int a = 0; a < 8; a++) send_request(a[2:0], hi, -64'sd1);
        send_request(mau_pkg::ACT_POW, 64'd3, 64'd0);          // zero exponent
        send_request(mau_pkg::ACT_POW, 64'd2, lo);             // most negative exponent
        send_request(mau_pkg::ACT_POW, 64'd0, -64'sd3);        // no inverse of zero
        send_request(mau_pkg::ACT_DIV, 64'd5, 64'd998244353);  // divisor reduces to zero
        send_request(mau_pkg::ACT_INV, 64'd0, 64'd0);
        send_request(mau_pkg::ACT_NEG, 64'd0, 64'd0);
        send_request(mau_pkg::ACT_SUB, 64'd0, 64'd1);
        drain_results();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        logic [2:0] act;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int n = 0; n < count; n++) begin
            act = 3'($urandom_range(7));
            send_request(act, random_operand(),
                         (mau_pkg::action_t'(act) == mau_pkg::ACT_POW) ? random_exponent()
                                                                       : random_operand());
        end
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (600) @(posedge aclk);
                recv_hold = 1'b0;
            end
            for (int n = 0; n < 6; n++)
                send_request(mau_pkg::ACT_ADD, random_operand(), random_operand());
        join
        drain_results();
    endtask

    task automatic test_modulus_settings();
        logic [31:0] moduli[6];
        moduli = '{32'd2, 32'd0, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFC, 32'd12};
        foreach (moduli[k]) begin
            repeat (20) @(posedge aclk);
            write_modulus(moduli[k]);
            test_random(12, 17, 17);
            for (int a = 0; a < 8; a++) send_request(a[2:0], random_operand(), -64'sd2);
            drain_results();
        end
        repeat (20) @(posedge aclk);
        write_modulus(32'd998244353);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(40, 0, 0);
        test_random(30, 63, 0);
        test_random(30, 0, 63);
        test_random(30, 17, 17);
        test_backpressure();
        test_modulus_settings();
        test_random(25, 0, 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/mau_pkg.sv
design/mau_datapath.sv
design/mau_ctrl.sv
design/modular_arithmetic_unit.sv
tb/testbench.sv
